/* hdl/lsdl_pkg.sv */
// Shared types and constants of the line-scan dark line locator.
package lsdl_pkg;

    localparam int IDX_BITS      = 7;
    localparam int PIX_BITS      = 12;
    localparam int SUM_BITS      = 16;
    localparam int FRM_BITS      = 4;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [SUM_BITS-1:0] SUM_MAX  = {SUM_BITS{1'b1}};
    localparam logic [PIX_BITS-1:0] DIFF_MAX = {PIX_BITS{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_FIRST = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_LAST  = 2'd2;

    localparam logic [PIX_BITS-1:0] THR_RESET       = 12'd70;
    localparam logic [IDX_BITS-1:0] WIN_FIRST_RESET = 7'd15;
    localparam logic [IDX_BITS-1:0] WIN_LAST_RESET  = 7'd112;
    localparam logic [IDX_BITS-1:0] POS_RESET       = 7'd63;

    typedef struct packed {
        logic                action;
        logic [IDX_BITS-1:0] pixel_index;
        logic [PIX_BITS-1:0] pixel_value;
        logic                last_pixel;
    } t_in_item;

    typedef struct packed {
        logic [IDX_BITS-1:0] position;
        logic                line_found;
        logic [PIX_BITS-1:0] peak_difference;
        logic                baseline_ready;
    } t_out_item;

    typedef struct packed {
        logic [PIX_BITS-1:0] threshold;
        logic [IDX_BITS-1:0] win_first;
        logic [IDX_BITS-1:0] win_last;
    } t_cfg;

    // Item leaving the sum store toward the peak tracker
    typedef struct packed {
        logic                valid;
        logic                action;
        logic                on_line;
        logic [IDX_BITS-1:0] pixel_index;
        logic [PIX_BITS-1:0] pixel_value;
        logic                last_pixel;
        logic [SUM_BITS-1:0] base;
        logic                ready;
    } t_stage2;

    typedef struct packed {
        logic clearing;
        logic ready;
    } t_store_status;

endpackage

/* hdl/lsdl_base_store.sv */
// Baseline sum memory with read-modify-write, frame counter and averaging divide.
module lsdl_base_store #(
    parameter int LINE_PIXELS = 128,
    parameter int BASE_FRAMES = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,
    input  logic                   i_accept,
    input  lsdl_pkg::t_in_item     i_item,
    output lsdl_pkg::t_stage2      o_s2,
    output lsdl_pkg::t_store_status o_status
);
    import lsdl_pkg::*;

    localparam int AW          = $clog2(LINE_PIXELS);
    localparam int XW          = (AW > IDX_BITS) ? AW : IDX_BITS;
    localparam int RECIP_SHIFT = SUM_BITS + $clog2(BASE_FRAMES);
    localparam int MW          = SUM_BITS + 1;
    localparam int PW          = SUM_BITS + MW;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(BASE_FRAMES) - 64'd1) / 64'(BASE_FRAMES);
    localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

    logic [SUM_BITS-1:0] mem [LINE_PIXELS];

    logic [SUM_BITS-1:0] r_rd_data;
    logic                r_s1_valid;
    t_in_item            r_s1_item;
    logic [AW-1:0]       r_s1_addr;
    logic                r_s1_on_line;
    logic                r_fwd_valid;
    logic [AW-1:0]       r_fwd_addr;
    logic [SUM_BITS-1:0] r_fwd_data;
    logic [FRM_BITS-1:0] r_frames;
    logic                r_clearing;
    logic [AW-1:0]       r_clr_addr;
    logic                r_s2_valid;
    t_stage2             r_s2;

    logic [XW-1:0]       w_in_ext;
    logic [AW-1:0]       w_rd_addr;
    logic                w_in_on_line;
    logic                w_ready;
    logic [SUM_BITS-1:0] w_sum;
    logic [SUM_BITS:0]   w_acc;
    logic [SUM_BITS-1:0] w_sum_sat;
    logic                w_is_base;
    logic                w_item_we;
    logic                w_frame_end;
    logic [FRM_BITS-1:0] w_frames_next;
    logic                w_ready_after;
    logic [PW-1:0]       w_prod;
    logic [PW-1:0]       w_shifted;
    logic                w_we;
    logic [AW-1:0]       w_wa;
    logic [SUM_BITS-1:0] w_wd;

    assign w_in_ext     = XW'(i_item.pixel_index);
    assign w_rd_addr    = w_in_ext[AW-1:0];
    assign w_in_on_line = 32'(i_item.pixel_index) < 32'(LINE_PIXELS);

    assign w_ready = r_frames >= FRM_BITS'(BASE_FRAMES);

    // Forward the write of the previous item, which the read did not see
    assign w_sum = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : r_rd_data;
    assign w_acc = {1'b0, w_sum} + (SUM_BITS + 1)'(r_s1_item.pixel_value);
    assign w_sum_sat = w_acc[SUM_BITS] ? SUM_MAX : w_acc[SUM_BITS-1:0];

    assign w_is_base     = r_s1_valid && !r_s1_item.action && !w_ready;
    assign w_item_we     = i_advance && w_is_base && r_s1_on_line;
    assign w_frame_end   = w_is_base && r_s1_item.last_pixel;
    assign w_frames_next = r_frames + FRM_BITS'(1);
    assign w_ready_after = w_frame_end ? (w_frames_next >= FRM_BITS'(BASE_FRAMES)) : w_ready;

    // Divide by BASE_FRAMES: multiply by the rounded-up reciprocal
    assign w_prod    = PW'(w_sum) * PW'(RECIP_M);
    assign w_shifted = w_prod >> RECIP_SHIFT;

    assign w_we = r_clearing || w_item_we;
    assign w_wa = r_clearing ? r_clr_addr : r_s1_addr;
    assign w_wd = r_clearing ? '0 : w_sum_sat;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        if (i_advance) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_frames    <= '0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s2_valid  <= 1'b0;
        end else begin
            if (r_clearing) begin
                if (r_clr_addr == AW'(LINE_PIXELS - 1)) begin
                    r_clearing <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_advance) begin
                r_s1_valid  <= i_accept;
                r_fwd_valid <= w_item_we;
                r_s2_valid  <= r_s1_valid;
                if (w_frame_end) begin
                    r_frames <= w_frames_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_s1_item    <= i_item;
            r_s1_addr    <= w_rd_addr;
            r_s1_on_line <= w_in_on_line;
            r_fwd_addr   <= r_s1_addr;
            r_fwd_data   <= w_sum_sat;
            r_s2.valid       <= 1'b0;
            r_s2.action      <= r_s1_item.action;
            r_s2.on_line     <= r_s1_on_line;
            r_s2.pixel_index <= r_s1_item.pixel_index;
            r_s2.pixel_value <= r_s1_item.pixel_value;
            r_s2.last_pixel  <= r_s1_item.last_pixel;
            r_s2.base        <= w_shifted[SUM_BITS-1:0];
            r_s2.ready       <= w_ready_after;
        end
    end

    always_comb begin
        o_s2       = r_s2;
        o_s2.valid = r_s2_valid;
    end

    assign o_status.clearing = r_clearing;
    assign o_status.ready    = w_ready;

endmodule

/* hdl/lsdl_peak_track.sv */
// Difference, windowed peak search, line position and output register.
module lsdl_peak_track (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lsdl_pkg::t_cfg      i_cfg,
    input  lsdl_pkg::t_stage2   i_s2,
    input  logic                i_out_stall,
    output logic                o_advance,
    output logic                o_out_valid,
    output lsdl_pkg::t_out_item o_out_item
);
    import lsdl_pkg::*;

    logic [PIX_BITS-1:0] r_best_diff;
    logic [IDX_BITS-1:0] r_best_idx;
    logic                r_found;
    logic [IDX_BITS-1:0] r_line_pos;
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic                w_emit;
    logic                w_darker;
    logic [SUM_BITS-1:0] w_raw;
    logic [PIX_BITS-1:0] w_diff;
    logic                w_in_win;
    logic                w_take;
    logic [PIX_BITS-1:0] n_best_diff;
    logic [IDX_BITS-1:0] n_best_idx;
    logic                n_found;
    t_out_item           w_result;

    assign w_emit    = i_s2.valid && i_s2.last_pixel;
    // Hold the pipe only when a new result meets a result still waiting
    assign o_advance = !(w_emit && r_out_valid && i_out_stall);

    assign w_darker = i_s2.base > SUM_BITS'(i_s2.pixel_value);
    assign w_raw    = w_darker ? (i_s2.base - SUM_BITS'(i_s2.pixel_value)) : '0;
    assign w_diff   = (w_raw > SUM_BITS'(DIFF_MAX)) ? DIFF_MAX : w_raw[PIX_BITS-1:0];

    assign w_in_win = i_s2.on_line && (i_s2.pixel_index >= i_cfg.win_first)
                      && (i_s2.pixel_index <= i_cfg.win_last);
    assign w_take   = i_s2.valid && i_s2.action && w_in_win
                      && (w_diff > r_best_diff) && (w_diff > i_cfg.threshold);

    assign n_best_diff = w_take ? w_diff : r_best_diff;
    assign n_best_idx  = w_take ? i_s2.pixel_index : r_best_idx;
    assign n_found     = r_found || w_take;

    always_comb begin
        w_result.baseline_ready = i_s2.ready;
        if (i_s2.action) begin
            w_result.position        = n_found ? n_best_idx : r_line_pos;
            w_result.line_found      = n_found;
            w_result.peak_difference = n_found ? n_best_diff : '0;
        end else begin
            w_result.position        = r_line_pos;
            w_result.line_found      = 1'b0;
            w_result.peak_difference = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_diff <= '0;
            r_best_idx  <= '0;
            r_found     <= 1'b0;
            r_line_pos  <= POS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance && i_s2.valid && i_s2.action) begin
                if (i_s2.last_pixel) begin
                    r_line_pos  <= w_result.position;
                    r_best_diff <= '0;
                    r_best_idx  <= '0;
                    r_found     <= 1'b0;
                end else begin
                    r_best_diff <= n_best_diff;
                    r_best_idx  <= n_best_idx;
                    r_found     <= n_found;
                end
            end
            if (o_advance && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && w_emit) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* hdl/line_scan_dark_line_locator_core.sv */
// A result reaches o_out_valid through the stage-one, stage-two and output registers.
// Throughput: one pixel item per cycle unless stalled, set by the one-read one-write port
// of the sum memory (read in the accept cycle, written back in the next stage with
// forwarding between items). Input stalls in the clearing pass and while a new result
// meets an earlier result that is still not taken. Reset: synchronous, active low; then
// a clearing pass zeroes the sum memory; it accepts no item but still takes config writes.
module line_scan_dark_line_locator_core #(
    parameter int LINE_PIXELS = 128,
    parameter int BASE_FRAMES = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lsdl_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [lsdl_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  lsdl_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output lsdl_pkg::t_out_item                 o_out_item
);
    import lsdl_pkg::*;

    t_cfg          r_cfg;
    logic          w_advance;
    logic          w_accept;
    t_stage2       w_s2;
    t_store_status w_status;

    // Configuration registers: threshold and search window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= THR_RESET;
            r_cfg.win_first <= WIN_FIRST_RESET;
            r_cfg.win_last  <= WIN_LAST_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_cfg.threshold <= i_cfg_data[PIX_BITS-1:0];
                CFG_WIN_FIRST: r_cfg.win_first <= i_cfg_data[IDX_BITS-1:0];
                CFG_WIN_LAST:  r_cfg.win_last  <= i_cfg_data[IDX_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Hold input off during the clearing pass and whenever the pipe must hold
    assign o_in_stall = !w_advance || w_status.clearing;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Sum store: accept stage reads, next stage adds and writes back, then divides
    lsdl_base_store #(
        .LINE_PIXELS(LINE_PIXELS),
        .BASE_FRAMES(BASE_FRAMES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_accept  (w_accept),
        .i_item    (i_in_item),
        .o_s2      (w_s2),
        .o_status  (w_status)
    );

    // Peak tracker: difference against baseline, first strict maximum, report at frame end
    lsdl_peak_track u_peak (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_s2        (w_s2),
        .i_out_stall (i_out_stall),
        .o_advance   (w_advance),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

`ifndef NO_ASSERTIONS
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.clearing |-> !w_s2.valid)
        else $error("item in pipe during clearing pass");

    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(w_status.ready))
        else $error("baseline ready dropped without reset");

    a_no_peak_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.line_found) |-> (o_out_item.peak_difference == '0))
        else $error("peak difference reported without a line");

    a_peak_over_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.line_found) |->
        (o_out_item.peak_difference > r_cfg.threshold))
        else $error("line reported at or below threshold");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the line-scan dark line locator core.
`timescale 1ns / 100ps

module tb_top;
    import lsdl_pkg::*;

    localparam int LINE_PIXELS = 128;
    localparam int BASE_FRAMES = 10;

    // Pixel kinds carried in the action field of an item
    localparam logic ACT_BASELINE = 1'b0;
    localparam logic ACT_DETECT   = 1'b1;

    // Cycles to let the pipeline empty before touching the registers
    localparam int SETTLE_CYCLES = 8;
    // Cycles with no accepted item on either side before the run is called hung
    localparam int QUIET_LIMIT   = 4000;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_THRESHOLD;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    t_in_item                 in_item   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    t_out_item                out_item;

    // Sender and receiver behavior, set per phase by the stimulus process
    logic hold_off  = 1'b1;
    int   idle_pct  = 0;
    int   stall_pct = 0;

    t_in_item  pixel_feed[$];
    t_out_item pending_results[$];

    int fail_count      = 0;
    int items_taken     = 0;
    int results_checked = 0;
    int lines_seen      = 0;
    int settings_used   = 0;
    int quiet_cycles    = 0;

    // Predictor state: per-pixel baseline sums, frame count, peak tracking
    logic [SUM_BITS-1:0] dark_sum [LINE_PIXELS];
    logic [FRM_BITS-1:0] frames_summed = '0;
    logic [PIX_BITS-1:0] peak_so_far   = '0;
    logic [IDX_BITS-1:0] peak_idx      = '0;
    logic [IDX_BITS-1:0] track_pos     = POS_RESET;
    logic                seen_dark     = 1'b0;
    logic [PIX_BITS-1:0] thr_cfg       = THR_RESET;
    logic [IDX_BITS-1:0] first_cfg     = WIN_FIRST_RESET;
    logic [IDX_BITS-1:0] last_cfg      = WIN_LAST_RESET;

    always #2 clk = ~clk;

    line_scan_dark_line_locator_core #(
        .LINE_PIXELS (LINE_PIXELS),
        .BASE_FRAMES (BASE_FRAMES)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    task automatic flag_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        fail_count++;
    endtask

    // Advance the predictor by one pixel item; returns 1 when the item ends a
    // frame and so yields a result, which is written to res.
    function automatic bit predict_scan_result(input t_in_item px, output t_out_item res);
        int grown;
        int base;
        int diff;
        res = '0;
        if (px.action == ACT_BASELINE) begin
            // Once the baseline is complete, baseline pixels are dropped
            if (frames_summed < BASE_FRAMES) begin
                grown = dark_sum[px.pixel_index] + px.pixel_value;
                dark_sum[px.pixel_index] = (grown > SUM_MAX) ? SUM_MAX : SUM_BITS'(grown);
                if (px.last_pixel)
                    frames_summed = frames_summed + 1'b1;
            end
            if (!px.last_pixel)
                return 1'b0;
            res.position       = track_pos;
            res.baseline_ready = (frames_summed >= BASE_FRAMES);
            return 1'b1;
        end
        // Detection pixel: only the window is searched; an empty window searches nothing
        if (px.pixel_index >= first_cfg && px.pixel_index <= last_cfg) begin
            base = dark_sum[px.pixel_index] / BASE_FRAMES;
            diff = base - int'(px.pixel_value);
            if (diff < 0)
                diff = 0;
            if (diff > DIFF_MAX)
                diff = DIFF_MAX;
            // Strictly greater keeps the first of equal peaks
            if (diff > peak_so_far && diff > thr_cfg) begin
                peak_so_far = PIX_BITS'(diff);
                peak_idx    = px.pixel_index;
                seen_dark   = 1'b1;
            end
        end
        if (!px.last_pixel)
            return 1'b0;
        if (seen_dark)
            track_pos = peak_idx;
        res.position        = track_pos;
        res.line_found      = seen_dark;
        res.peak_difference = seen_dark ? peak_so_far : '0;
        res.baseline_ready  = (frames_summed >= BASE_FRAMES);
        peak_so_far = '0;
        peak_idx    = '0;
        seen_dark   = 1'b0;
        return 1'b1;
    endfunction

    // Drive pixel items: hold a stalled item, predict on acceptance, then
    // load the next item from the feed unless this cycle idles.
    always @(posedge clk) begin : pixel_driver
        t_out_item res;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                items_taken++;
                if (predict_scan_result(in_item, res))
                    pending_results.push_back(res);
            end
            if (!(in_valid && in_stall)) begin
                if (!hold_off && pixel_feed.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    in_valid <= 1'b1;
                    in_item  <= pixel_feed.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Take results, compare each against the oldest expectation, then
    // decide whether to stall the next cycle.
    always @(posedge clk) begin : result_monitor
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("frame result arrived with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (want.line_found)
                        lines_seen++;
                    if (out_item.position !== want.position)
                        flag_mismatch($sformatf("position got %0d expected %0d",
                                                out_item.position, want.position));
                    if (out_item.line_found !== want.line_found)
                        flag_mismatch($sformatf("line_found got %0b expected %0b",
                                                out_item.line_found, want.line_found));
                    if (out_item.peak_difference !== want.peak_difference)
                        flag_mismatch($sformatf("peak_difference got %0d expected %0d",
                                                out_item.peak_difference,
                                                want.peak_difference));
                    if (out_item.baseline_ready !== want.baseline_ready)
                        flag_mismatch($sformatf("baseline_ready got %0b expected %0b",
                                                out_item.baseline_ready,
                                                want.baseline_ready));
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Count cycles in which nothing moves on either side; end a hung run.
    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_pixel(input logic act, input int idx, input int val, input logic fin);
        t_in_item px;
        px.action      = act;
        px.pixel_index = IDX_BITS'(idx);
        px.pixel_value = PIX_BITS'(val);
        px.last_pixel  = fin;
        pixel_feed.push_back(px);
    endtask

    // Baseline frame of n pixels at random positions, mostly bright
    task automatic add_baseline_frame(input int n);
        int val;
        for (int k = 0; k < n; k++) begin
            val = ($urandom_range(9) < 7) ? $urandom_range(4095, 1500) : $urandom_range(4095);
            add_pixel(ACT_BASELINE, $urandom_range(127), val, k == n - 1);
        end
    endtask

    // Detection frame of n pixels, mostly inside the window and dark,
    // with some repeated pixels to exercise equal peaks
    task automatic add_detect_frame(input int n);
        int idx;
        int val;
        idx = 0;
        val = 0;
        for (int k = 0; k < n; k++) begin
            if (k == 0 || $urandom_range(99) >= 15) begin
                if (first_cfg <= last_cfg && $urandom_range(9) < 8)
                    idx = $urandom_range(last_cfg, first_cfg);
                else
                    idx = $urandom_range(127);
                val = ($urandom_range(9) < 6) ? $urandom_range(600) : $urandom_range(4095);
            end
            add_pixel(ACT_DETECT, idx, val, k == n - 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(val);
    endtask

    // Write all three registers; the block is idle here
    task automatic set_scan_config(input int thr, input int wfirst, input int wlast);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_WIN_FIRST, wfirst);
        write_reg(CFG_WIN_LAST, wlast);
        @(posedge clk);
        cfg_we    <= 1'b0;
        thr_cfg   = PIX_BITS'(thr);
        first_cfg = IDX_BITS'(wfirst);
        last_cfg  = IDX_BITS'(wlast);
        settings_used++;
    endtask

    // Release the queued items with the given idle and stall rates, wait until every
    // expected result has come back, then pause the sender
    task automatic run_feed(input int idle, input int stall);
        @(posedge clk);
        idle_pct  <= idle;
        stall_pct <= stall;
        hold_off  <= 1'b0;
        @(negedge clk);
        while (pixel_feed.size() != 0 || in_valid || pending_results.size() != 0)
            @(negedge clk);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        int detect_items;
        int n;
        int thr;
        int wa;
        int wb;
        for (int k = 0; k < LINE_PIXELS; k++)
            dark_sum[k] = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset configuration (threshold 70, window 15..112).
        // One baseline frame, so detection runs on a partial baseline.
        add_pixel(ACT_BASELINE, 0, 4095, 1'b0);
        add_pixel(ACT_BASELINE, 20, 4095, 1'b0);
        add_pixel(ACT_BASELINE, 30, 4095, 1'b0);
        add_pixel(ACT_BASELINE, 112, 4000, 1'b0);
        add_pixel(ACT_BASELINE, 15, 1000, 1'b0);
        add_pixel(ACT_BASELINE, 127, 0, 1'b1);
        // Pixels outside the window are skipped; deepest in-window pixel wins
        add_pixel(ACT_DETECT, 0, 0, 1'b0);
        add_pixel(ACT_DETECT, 15, 0, 1'b0);
        add_pixel(ACT_DETECT, 20, 0, 1'b0);
        add_pixel(ACT_DETECT, 112, 0, 1'b0);
        add_pixel(ACT_DETECT, 127, 4095, 1'b1);
        // Nothing darker: previous position is kept
        add_pixel(ACT_DETECT, 20, 4095, 1'b1);
        // Equal peaks at two positions: the first one seen wins
        add_pixel(ACT_DETECT, 30, 0, 1'b0);
        add_pixel(ACT_DETECT, 20, 0, 1'b1);
        // Difference equal to the threshold does not count, one above does
        add_pixel(ACT_DETECT, 20, 339, 1'b1);
        add_pixel(ACT_DETECT, 20, 338, 1'b1);
        run_feed(0, 0);

        // Remaining baseline frames; the second one drives one sum into saturation
        for (int f = 1; f < BASE_FRAMES; f++) begin
            if (f == 1)
                for (int k = 0; k < 17; k++)
                    add_pixel(ACT_BASELINE, 50, 4095, 1'b0);
            add_baseline_frame(55);
        end
        run_feed(78, 0);

        // Saturated baseline gives a clipped difference; late baseline frames are ignored
        add_pixel(ACT_DETECT, 50, 0, 1'b1);
        add_pixel(ACT_BASELINE, 5, 100, 1'b0);
        add_pixel(ACT_BASELINE, 127, 4095, 1'b1);
        run_feed(12, 12);

        // Random detection frames under a series of register settings
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_scan_config(0, 0, 127);
                1: set_scan_config(4095, 0, 127);
                2: begin
                    wa = $urandom_range(127);
                    set_scan_config($urandom_range(300), wa, wa);
                end
                3: set_scan_config($urandom_range(300), $urandom_range(127, 64),
                                   $urandom_range(63));
                default: begin
                    thr = $urandom_range(800);
                    wa  = $urandom_range(127);
                    wb  = $urandom_range(127);
                    if (wa <= wb)
                        set_scan_config(thr, wa, wb);
                    else
                        set_scan_config(thr, wb, wa);
                end
            endcase
            detect_items = 0;
            while (detect_items < 70) begin
                if ($urandom_range(9) == 0) begin
                    add_baseline_frame($urandom_range(4, 1));
                end else begin
                    n = $urandom_range(20, 1);
                    add_detect_frame(n);
                    detect_items += n;
                end
            end
            case (p % 4)
                0: run_feed(0, 0);
                1: run_feed(78, 0);
                2: run_feed(0, 78);
                default: run_feed(12, 12);
            endcase
        end

        if (pending_results.size() != 0)
            flag_mismatch($sformatf("%0d frame results never arrived", pending_results.size()));
        $display("Run covered %0d pixel items and %0d frame results, %0d with a line found,",
                 items_taken, results_checked, lines_seen);
        $display("across %0d register settings and four idle/stall patterns.", settings_used + 1);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
